### rtl/core/exp_taylor_series_defines.svh
// ----------------------------------------------------------------------------
// exp_taylor_series_defines: assertion macros
// Shared assertion forms for the exponential series block.
// ----------------------------------------------------------------------------
`ifndef EXP_TAYLOR_SERIES_DEFINES_SVH
`define EXP_TAYLOR_SERIES_DEFINES_SVH

// Same-cycle implication, off during reset
`define ETX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etx assertion failed");

// Next-cycle implication, off during reset
`define ETX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etx assertion failed");

`endif

### rtl/core/etx_pkg.sv
// ----------------------------------------------------------------------------
// etx_pkg: exponential series package
// Formats, reciprocal table and shared types of the exponential series block.
// ----------------------------------------------------------------------------
`default_nettype none

package etx_pkg;

    // Series length and fixed-point formats
    localparam int TERM_COUNT = 20;
    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 6;
    localparam int RECIP_BITS = 24;
    localparam int X_W        = 21;
    localparam int OUT_W      = 32;

    // Internal widths
    localparam int TERM_W    = OUT_W + GUARD_BITS + 1;
    localparam int MAG_W     = X_W;
    localparam int RECIP_W   = RECIP_BITS + 1;
    localparam int MUL_A_W   = TERM_W;
    localparam int MUL_B_W   = (RECIP_W > MAG_W) ? RECIP_W : MAG_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + $clog2(TERM_COUNT) + 1;
    localparam int K_W       = $clog2(TERM_COUNT);
    localparam int RECIP_DEPTH = 64;
    localparam int RIDX_W    = 6;

    // Term constants
    localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << (FRAC_BITS + GUARD_BITS);
    localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (OUT_W + GUARD_BITS);

    // 1/k in Q1.RECIP_BITS, rounded half up; entry 0 is unused
    localparam longint unsigned RONE = 64'd1 << RECIP_BITS;
    localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
        RECIP_W'(0),
        RECIP_W'((RONE + 64'd0) / 64'd1),   RECIP_W'((RONE + 64'd1) / 64'd2),
        RECIP_W'((RONE + 64'd1) / 64'd3),   RECIP_W'((RONE + 64'd2) / 64'd4),
        RECIP_W'((RONE + 64'd2) / 64'd5),   RECIP_W'((RONE + 64'd3) / 64'd6),
        RECIP_W'((RONE + 64'd3) / 64'd7),   RECIP_W'((RONE + 64'd4) / 64'd8),
        RECIP_W'((RONE + 64'd4) / 64'd9),   RECIP_W'((RONE + 64'd5) / 64'd10),
        RECIP_W'((RONE + 64'd5) / 64'd11),  RECIP_W'((RONE + 64'd6) / 64'd12),
        RECIP_W'((RONE + 64'd6) / 64'd13),  RECIP_W'((RONE + 64'd7) / 64'd14),
        RECIP_W'((RONE + 64'd7) / 64'd15),  RECIP_W'((RONE + 64'd8) / 64'd16),
        RECIP_W'((RONE + 64'd8) / 64'd17),  RECIP_W'((RONE + 64'd9) / 64'd18),
        RECIP_W'((RONE + 64'd9) / 64'd19),  RECIP_W'((RONE + 64'd10) / 64'd20),
        RECIP_W'((RONE + 64'd10) / 64'd21), RECIP_W'((RONE + 64'd11) / 64'd22),
        RECIP_W'((RONE + 64'd11) / 64'd23), RECIP_W'((RONE + 64'd12) / 64'd24),
        RECIP_W'((RONE + 64'd12) / 64'd25), RECIP_W'((RONE + 64'd13) / 64'd26),
        RECIP_W'((RONE + 64'd13) / 64'd27), RECIP_W'((RONE + 64'd14) / 64'd28),
        RECIP_W'((RONE + 64'd14) / 64'd29), RECIP_W'((RONE + 64'd15) / 64'd30),
        RECIP_W'((RONE + 64'd15) / 64'd31), RECIP_W'((RONE + 64'd16) / 64'd32),
        RECIP_W'((RONE + 64'd16) / 64'd33), RECIP_W'((RONE + 64'd17) / 64'd34),
        RECIP_W'((RONE + 64'd17) / 64'd35), RECIP_W'((RONE + 64'd18) / 64'd36),
        RECIP_W'((RONE + 64'd18) / 64'd37), RECIP_W'((RONE + 64'd19) / 64'd38),
        RECIP_W'((RONE + 64'd19) / 64'd39), RECIP_W'((RONE + 64'd20) / 64'd40),
        RECIP_W'((RONE + 64'd20) / 64'd41), RECIP_W'((RONE + 64'd21) / 64'd42),
        RECIP_W'((RONE + 64'd21) / 64'd43), RECIP_W'((RONE + 64'd22) / 64'd44),
        RECIP_W'((RONE + 64'd22) / 64'd45), RECIP_W'((RONE + 64'd23) / 64'd46),
        RECIP_W'((RONE + 64'd23) / 64'd47), RECIP_W'((RONE + 64'd24) / 64'd48),
        RECIP_W'((RONE + 64'd24) / 64'd49), RECIP_W'((RONE + 64'd25) / 64'd50),
        RECIP_W'((RONE + 64'd25) / 64'd51), RECIP_W'((RONE + 64'd26) / 64'd52),
        RECIP_W'((RONE + 64'd26) / 64'd53), RECIP_W'((RONE + 64'd27) / 64'd54),
        RECIP_W'((RONE + 64'd27) / 64'd55), RECIP_W'((RONE + 64'd28) / 64'd56),
        RECIP_W'((RONE + 64'd28) / 64'd57), RECIP_W'((RONE + 64'd29) / 64'd58),
        RECIP_W'((RONE + 64'd29) / 64'd59), RECIP_W'((RONE + 64'd30) / 64'd60),
        RECIP_W'((RONE + 64'd30) / 64'd61), RECIP_W'((RONE + 64'd31) / 64'd62),
        RECIP_W'((RONE + 64'd31) / 64'd63)
    };

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    // Finished result of one item
    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/etx_mul.sv
// ----------------------------------------------------------------------------
// etx_mul: shared multiplier
// Unsigned multiplier with a registered product, loaded when a request is on.
// ----------------------------------------------------------------------------
`default_nettype none

module etx_mul (
    input  wire logic                   i_clk,
    input  wire etx_pkg::t_mul_req      i_req,
    output logic [etx_pkg::PROD_W-1:0]  o_prod
);
    import etx_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### rtl/core/etx_core.sv
// ----------------------------------------------------------------------------
// etx_core: series sequencer
// Steps the term recurrence over the shared multiplier, accumulates the sum
// and rounds and clamps it at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module etx_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [etx_pkg::X_W-1:0] i_x,
    input  wire logic                        i_out_free,
    output logic                             o_idle,
    output logic                             o_done,
    output etx_pkg::t_result                 o_result
);
    import etx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MX,
        S_CAP,
        S_MR,
        S_ACC,
        S_FIN
    } t_state;

    localparam logic signed [SUM_W-1:0] SUM_HI =
        {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (GUARD_BITS - 1);
    localparam logic [K_W-1:0]          K_LAST = K_W'(TERM_COUNT - 1);

    t_state                   r_state, n_state;
    logic [K_W-1:0]           r_k, n_k;
    logic [TERM_W-1:0]        r_term, n_term;
    logic [TERM_W-1:0]        r_p, n_p;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic                     r_capped, n_capped;
    logic                     r_done, n_done;
    t_result                  r_result, n_result;

    t_mul_req                 mul_req;
    logic [PROD_W-1:0]        mul_prod;
    logic [SHIFT_W-1:0]       prod_shr;
    logic [TERM_W-1:0]        new_term;
    logic signed [SUM_W-1:0]  term_ext;
    logic signed [SUM_W-1:0]  rnd;

    etx_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // Datapath taps
    assign prod_shr = mul_prod[PROD_W-1:FRAC_BITS];
    assign new_term = mul_prod[RECIP_BITS +: TERM_W];
    assign term_ext = $signed(SUM_W'(new_term));
    assign rnd      = (r_sum + RND_HALF) >>> GUARD_BITS;

    // Multiplier operand select
    always_comb begin
        mul_req = '0;
        case (r_state)
            S_MX: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_term;
                mul_req.b  = MUL_B_W'(r_mag);
            end
            S_MR: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_p;
                mul_req.b  = MUL_B_W'(RECIP_TABLE[RIDX_W'(r_k)]);
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_term   = r_term;
        n_p      = r_p;
        n_sum    = r_sum;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_capped = r_capped;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_neg    = i_x[X_W-1];
                    n_mag    = i_x[X_W-1] ? MAG_W'(-i_x) : MAG_W'(i_x);
                    n_term   = TERM_ONE;
                    n_sum    = $signed(SUM_W'(TERM_ONE));
                    n_k      = K_W'(1);
                    n_capped = 1'b0;
                    n_state  = S_MX;
                end
            end
            S_MX: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                // limit the scaled product to the term cap
                if (prod_shr > SHIFT_W'(TERM_CAP)) begin
                    n_p      = TERM_CAP;
                    n_capped = 1'b1;
                end else begin
                    n_p = prod_shr[TERM_W-1:0];
                end
                n_state = S_MR;
            end
            S_MR: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                // odd powers of a negative x subtract
                n_term = new_term;
                if (r_neg && r_k[0]) begin
                    n_sum = r_sum - term_ext;
                end else begin
                    n_sum = r_sum + term_ext;
                end
                if (r_k == K_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_state = S_MX;
                end
            end
            S_FIN: begin
                // round, clamp, hand over when the output stage frees up
                if (i_out_free) begin
                    if (r_capped) begin
                        n_result.sat   = 1'b1;
                        n_result.value = r_sum[SUM_W-1] ? OUT_W'(SUM_LO) : OUT_W'(SUM_HI);
                    end else if (rnd > SUM_HI) begin
                        n_result.sat   = 1'b1;
                        n_result.value = OUT_W'(SUM_HI);
                    end else if (rnd < SUM_LO) begin
                        n_result.sat   = 1'b1;
                        n_result.value = OUT_W'(SUM_LO);
                    end else begin
                        n_result.sat   = 1'b0;
                        n_result.value = rnd[OUT_W-1:0];
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_k      <= n_k;
        r_term   <= n_term;
        r_p      <= n_p;
        r_sum    <= n_sum;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_capped <= n_capped;
        r_result <= n_result;
    end

    assign o_idle   = (r_state == S_IDLE) && !r_done;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

### rtl/core/exp_taylor_series.sv
// ----------------------------------------------------------------------------
// exp_taylor_series: fixed-point exponential by a truncated Taylor series
// One item at a time: a new input is accepted only while the core is idle.
// Each term makes two passes through the one shared multiplier.
// The output register holds a result while the next item is taken.
// Reset: synchronous, active low; clears sequencer state and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "exp_taylor_series_defines.svh"

module exp_taylor_series (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [etx_pkg::X_W-1:0]     i_x_value,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [etx_pkg::OUT_W-1:0]        o_exp_value,
    output logic                                    o_saturated
);
    import etx_pkg::*;

    logic    core_idle;
    logic    core_done;
    logic    out_free;
    t_result core_result;
    logic    r_out_valid;

    // Output stage is free when empty or being drained
    assign out_free = !r_out_valid || i_ready;

    etx_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && core_idle),
        .i_x        (i_x_value),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_result   (core_result)
    );

    // Output valid flag; the result itself sits in the core's register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_ready     = core_idle;
    assign o_valid     = r_out_valid;
    assign o_exp_value = core_result.value;
    assign o_saturated = core_result.sat;

    // Checks
    `ETX_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ETX_ASSERT_NEXT(a_done_shows_valid, i_clk, i_rst_n, core_done, o_valid)
    `ETX_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, core_done && $past(r_out_valid), $past(i_ready))

endmodule

`default_nettype wire

### dv/exp_taylor_series_tb.sv
// ----------------------------------------------------------------------------
// exp_taylor_series_tb: self-checking bench for the exponential series block
// Drives signed Q5.16 x values through the valid/ready input, predicts each
// series sum and saturation flag in fixed point, and checks every result in
// order under several sender and receiver idling patterns and back-pressure.
// ----------------------------------------------------------------------------
module exp_taylor_series_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_W          = etx_pkg::X_W;
    localparam int OUT_W        = etx_pkg::OUT_W;
    localparam int WATCHDOG_MAX = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_ITEMS  = 310;

    localparam longint unsigned PRODUCT_LIMIT =
        64'd1 << (OUT_W + etx_pkg::GUARD_BITS);
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [X_W-1:0]   i_x_value;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_exp_value;
    logic                    o_saturated;

    etx_pkg::t_result exp_results_q[$];
    int               error_count;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    bit               hold_request;
    int               hold_left;
    int               quiet_cycles;

    exp_taylor_series dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_x_value   (i_x_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_exp_value (o_exp_value),
        .o_saturated (o_saturated)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Series sum in fixed point: magnitude terms, sign from odd powers of x
    function automatic etx_pkg::t_result exp_series_predict(logic signed [X_W-1:0] x);
        longint unsigned  raw;
        longint unsigned  mag;
        longint unsigned  term_mag;
        longint unsigned  prod;
        longint unsigned  recip;
        longint           sum;
        longint           rounded;
        logic             neg;
        logic             capped;
        etx_pkg::t_result res;
        raw      = 64'(unsigned'(x));
        neg      = x[X_W-1];
        mag      = neg ? ((64'd1 << X_W) - raw) : raw;
        term_mag = 64'd1 << (etx_pkg::FRAC_BITS + etx_pkg::GUARD_BITS);
        sum      = longint'(term_mag);
        capped   = 1'b0;
        for (int k = 1; k < etx_pkg::TERM_COUNT; k++) begin
            prod = (term_mag * mag) >> etx_pkg::FRAC_BITS;
            if (prod > PRODUCT_LIMIT) begin
                prod   = PRODUCT_LIMIT;
                capped = 1'b1;
            end
            // 1/k rounded half up
            recip    = ((64'd1 << etx_pkg::RECIP_BITS) + (longint'(k) >> 1)) / longint'(k);
            term_mag = (prod * recip) >> etx_pkg::RECIP_BITS;
            if (neg && k[0])
                sum = sum - longint'(term_mag);
            else
                sum = sum + longint'(term_mag);
        end
        res.sat = 1'b0;
        if (capped) begin
            // term overflow: clamp to the end matching the sign of the sum
            res.sat   = 1'b1;
            res.value = (sum >= 0) ? OUT_MAX[OUT_W-1:0] : OUT_MIN[OUT_W-1:0];
        end else begin
            rounded = (sum + (64'sd1 <<< (etx_pkg::GUARD_BITS - 1))) >>> etx_pkg::GUARD_BITS;
            if (rounded > OUT_MAX) begin
                rounded = OUT_MAX;
                res.sat = 1'b1;
            end else if (rounded < OUT_MIN) begin
                rounded = OUT_MIN;
                res.sat = 1'b1;
            end
            res.value = rounded[OUT_W-1:0];
        end
        return res;
    endfunction

    // Random x: mostly in -8..+8, some near the saturation edge, some anywhere
    function automatic logic signed [X_W-1:0] random_x();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 55)
            v = int'($urandom_range(1048576)) - 524288;
        else if (sel < 70)
            v = int'($urandom_range(760000, 620000));
        else if (sel < 80)
            v = int'($urandom_range(8191)) - 4096;
        else
            v = int'($urandom());
        return v[X_W-1:0];
    endfunction

    // Send one item; optional idle gap first, then hold until accepted
    task automatic send_x(logic signed [X_W-1:0] x);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_all_results();
        while (exp_results_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        i_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Result check first, then record the item accepted at the same edge
    always @(posedge i_clk) begin
        etx_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (exp_results_q.size() == 0) begin
                    $error("unexpected result: exp_value %0d saturated %0d",
                           o_exp_value, o_saturated);
                    error_count++;
                end else begin
                    want = exp_results_q.pop_front();
                    if (o_exp_value !== want.value) begin
                        $error("exp_value mismatch: expected %0d, got %0d",
                               want.value, o_exp_value);
                        error_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $error("saturated mismatch: expected %0d, got %0d",
                               want.sat, o_saturated);
                        error_count++;
                    end
                end
            end
            if (i_valid && o_ready)
                exp_results_q.push_back(exp_series_predict(i_x_value));
        end
    end

    // Watchdog on cycles with no accepted item on either side
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("exp_taylor_series test failed");
                $finish;
            end
        end
    end

    // Edges of the field, unit values, saturation edge and term overflow
    task automatic test_directed();
        logic signed [X_W-1:0] vals[$];
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        vals = '{21'sd0, 21'sd1, -21'sd1, 21'sd65536, -21'sd65536, 21'sd32768,
                 -21'sd32768, 21'sd524288, -21'sd524288, 21'sd681000, 21'sd681500,
                 21'sd700000, -21'sd700000, 21'sd1048575, -21'sd1048576,
                 21'sd900000, -21'sd900000, 21'sd4096};
        foreach (vals[i])
            send_x(vals[i]);
        i_valid <= 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
            send_x(random_x());
    endtask

    // Long receiver hold-off while the sender keeps offering items
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b1;
        repeat (12)
            send_x(random_x());
    endtask

    // Sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        sender_idle_pct    = 0;
        receiver_stall_pct = 12;
        repeat (10)
            send_x(random_x());
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_all_results();
        repeat (10)
            send_x(random_x());
    endtask

    // Sequence
    initial begin
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_x_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(68, 0, PHASE_ITEMS);
        test_random_phase(0, 68, PHASE_ITEMS);
        test_random_phase(12, 12, PHASE_ITEMS);
        test_backpressure();
        test_drain_pause();

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (exp_results_q.size() != 0) begin
            $error("%0d results never arrived", exp_results_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("exp_taylor_series test passed");
        else
            $display("exp_taylor_series test failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/etx_pkg.sv
rtl/core/etx_mul.sv
rtl/core/etx_core.sv
rtl/core/exp_taylor_series.sv
dv/exp_taylor_series_tb.sv
